### rtl/kspc_pkg.sv
// Shared types and constants for the keypad servo PWM controller.
package kspc_pkg;

  localparam logic [4:0]  ANGLE_MAX    = 5'd18;
  localparam logic [4:0]  ANGLE_RESET  = 5'd9;
  localparam logic [15:0] HIGH_RESET   = 16'd4500;
  localparam logic [15:0] PHASE_RESET  = 16'd60000;
  localparam logic [15:0] BASE_RESET   = 16'd3000;
  localparam logic [11:0] STEP_RESET   = 12'd300;
  localparam logic [15:0] PERIOD_RESET = 16'd60000;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_ONE       = 4'd1;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_POUND     = 4'd11;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_STEP   = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;

  typedef struct packed {
    logic [15:0] frame_period;
    logic [11:0] pulse_step;
    logic [15:0] pulse_base;
  } cfg_t;

  typedef struct packed {
    logic [3:0] key_code;
    logic       cmd;
  } item_t;

  typedef struct packed {
    logic        digit_pending;
    logic [15:0] pulse_ticks;
    logic [4:0]  angle_tens;
    logic        pwm_out;
  } result_t;

endpackage

### rtl/kspc_core.sv
// Servo state: key decoding, pulse width update and PWM phase countdown.
module kspc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  kspc_pkg::item_t  item,
  input  kspc_pkg::cfg_t   cfg,
  output kspc_pkg::result_t result
);
  import kspc_pkg::*;

  logic [4:0]  angle, angle_next;
  logic [15:0] high, high_next;
  logic        pending, pending_next;
  logic        first, first_next;
  logic        pin, pin_next;
  logic [15:0] phase, phase_next;

  logic        update;
  logic [16:0] product;
  logic [17:0] width_sum;

  assign product   = 17'(cfg.pulse_step) * 17'(angle_next);
  assign width_sum = 18'(cfg.pulse_base) + 18'(product);

  always_comb begin
    angle_next   = angle;
    pending_next = pending;
    first_next   = first;
    pin_next     = pin;
    phase_next   = phase;
    update       = 1'b0;
    if (step) begin
      if (item.cmd == CMD_KEY) begin
        if (item.key_code == KEY_STAR) begin
          if (angle != 5'd0) angle_next = angle - 5'd1;
          update = 1'b1;
        end else if (item.key_code == KEY_POUND) begin
          if (angle < ANGLE_MAX) angle_next = angle + 5'd1;
          update = 1'b1;
        end else if (item.key_code <= KEY_DIGIT_MAX) begin
          if (!pending) begin
            if (item.key_code <= KEY_ONE) begin
              first_next   = item.key_code[0];
              pending_next = 1'b1;
            end
          end else if (!(first && item.key_code == KEY_DIGIT_MAX)) begin
            angle_next   = first ? ({1'b0, item.key_code} + 5'd10) : {1'b0, item.key_code};
            pending_next = 1'b0;
            update       = 1'b1;
          end
        end
      end else begin
        if (phase <= 16'd1) begin
          pin_next = ~pin;
          if (!pin) begin
            phase_next = high;
          end else begin
            phase_next = (cfg.frame_period > high) ? (cfg.frame_period - high) : 16'd0;
          end
        end else begin
          phase_next = phase - 16'd1;
        end
      end
    end
  end

  always_comb begin
    high_next = high;
    if (update) begin
      if (width_sum > 18'(cfg.frame_period)) high_next = cfg.frame_period;
      else high_next = width_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle   <= ANGLE_RESET;
      high    <= HIGH_RESET;
      pending <= 1'b0;
      first   <= 1'b0;
      pin     <= 1'b0;
      phase   <= PHASE_RESET;
    end else begin
      angle   <= angle_next;
      high    <= high_next;
      pending <= pending_next;
      first   <= first_next;
      pin     <= pin_next;
      phase   <= phase_next;
    end
  end

  assign result.pwm_out       = pin_next;
  assign result.angle_tens    = angle_next;
  assign result.pulse_ticks   = high_next;
  assign result.digit_pending = pending_next;

endmodule

### rtl/keypad_servo_pwm_controller.sv
// Top level of the keypad servo PWM controller with stream ports and register writes.
// An accepted transaction passes the input register, then the result register, to m_tdata.
// Throughput: one transaction per cycle; the input register feeds the state logic and
// the result register, and both stall together only when the result is not taken.
// Reset (synchronous, active high) restores angle 9, high time 4500, pin low,
// phase 60000 and the default register values, and empties both stages.
module keypad_servo_pwm_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // key_code [3:0], zero fill above
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pwm_out, angle_tens, pulse_ticks, digit_pending, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kspc_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t core_result;
  result_t out_result;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_base   <= BASE_RESET;
      cfg.pulse_step   <= STEP_RESET;
      cfg.frame_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE:   cfg.pulse_base   <= cfg_data;
        CFG_STEP:   cfg.pulse_step   <= cfg_data[11:0];
        CFG_PERIOD: cfg.frame_period <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd      <= s_tuser;
      in_item.key_code <= s_tdata[3:0];
    end
  end

  kspc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (in_valid && advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {1'b0, out_result};

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:1] <= ANGLE_MAX))
    else $error("Result angle out of range.");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("Accepted transaction lost in the input stage.");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("Input stage changed while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> m_tvalid)
    else $error("Processed transaction produced no result.");

endmodule
